FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/tsb_pkg.sv
package tsb_pkg;

    localparam int MAX_ROWS     = 4096;
    localparam int DECAY_MAX    = 100;
    localparam int TANH_ENTRIES = 1024;

    localparam int ROW_W       = 12;
    localparam int DECAY_W     = 7;
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int DECAY_CODES = 2 ** DECAY_W;

    localparam int NUM_W       = ROW_W + 9;
    localparam int RECIP_SHIFT = NUM_W + $clog2(DECAY_MAX);
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int QC_W        = 12;
    localparam int Q_SAT       = 2 ** QC_W - 1;
    localparam int TIDX_W      = $clog2(TANH_ENTRIES);
    localparam int TANH_W      = 17;
    localparam int TANHS_W     = TANH_W + 1;
    localparam int ALPHA_W     = 16;

    localparam logic [63:0]       ONE_Q32  = 64'h1_0000_0000;
    localparam logic [TANH_W-1:0] TANH_ONE = TANH_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FOCUS_TOP,
        CFG_FOCUS_BOTTOM,
        CFG_DECAY
    } t_cfg_idx;

    typedef enum logic [1:0] {
        SGN_ZERO,
        SGN_POS,
        SGN_NEG
    } t_sgn;

    typedef struct packed {
        t_sgn sgn;
        logic hard;
    } t_tanh_ctl;

    typedef struct packed {
        logic [DECAY_W-1:0] half;
        logic               hard;
        logic [RECIP_W-1:0] recip;
    } t_edge_cfg;

    typedef struct packed {
        logic [2:0][PIX_W-1:0] sharp;
        logic [2:0][PIX_W-1:0] blur;
    } t_pix;

    function automatic logic [ROW_W-1:0] clamp_row(input logic [ROW_W-1:0] v);
        return (32'(v) > MAX_ROWS - 1) ? ROW_W'(MAX_ROWS - 1) : v;
    endfunction

    function automatic logic [DECAY_W-1:0] clamp_decay(input logic [DECAY_W-1:0] d);
        return (32'(d) > DECAY_MAX) ? DECAY_W'(DECAY_MAX) : d;
    endfunction

    // exp(-j/128) in Q32 by a truncated alternating Taylor series.
    function automatic logic [63:0] exp_neg_frac(input logic [7:0] j);
        logic [63:0] term;
        logic [63:0] jj;
        longint      sum;
        jj   = 64'(j);
        term = ONE_Q32;
        sum  = longint'(term);
        term = term * jj / 64'd128;  sum -= longint'(term);
        term = term * jj / 64'd256;  sum += longint'(term);
        term = term * jj / 64'd384;  sum -= longint'(term);
        term = term * jj / 64'd512;  sum += longint'(term);
        term = term * jj / 64'd640;  sum -= longint'(term);
        term = term * jj / 64'd768;  sum += longint'(term);
        term = term * jj / 64'd896;  sum -= longint'(term);
        term = term * jj / 64'd1024; sum += longint'(term);
        term = term * jj / 64'd1152; sum -= longint'(term);
        term = term * jj / 64'd1280; sum += longint'(term);
        term = term * jj / 64'd1408; sum -= longint'(term);
        term = term * jj / 64'd1536; sum += longint'(term);
        term = term * jj / 64'd1664; sum -= longint'(term);
        term = term * jj / 64'd1792; sum += longint'(term);
        term = term * jj / 64'd1920; sum -= longint'(term);
        term = term * jj / 64'd2048; sum += longint'(term);
        term = term * jj / 64'd2176; sum -= longint'(term);
        term = term * jj / 64'd2304; sum += longint'(term);
        term = term * jj / 64'd2432; sum -= longint'(term);
        term = term * jj / 64'd2560; sum += longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        return 64'(sum);
    endfunction

    // exp(-k/128) in Q32, capped at one.
    function automatic logic [63:0] exp_neg_q32(input int unsigned k);
        logic [63:0] p;
        logic [63:0] e1;
        int unsigned m;
        e1 = exp_neg_frac(8'd128);
        p  = exp_neg_frac(8'(k & 127));
        for (m = 0; m < (k >> 7); m++) begin
            p = (p * e1) >> 32;
        end
        if (p > ONE_Q32) begin
            p = ONE_Q32;
        end
        return p;
    endfunction

endpackage

FILE: hdl/tsb_tanh_lane.sv
module tsb_tanh_lane
    import tsb_pkg::*;
(
    input  logic                      i_clk,
    input  logic [ROW_W-1:0]          i_row,
    input  logic [ROW_W-1:0]          i_edge,
    input  t_edge_cfg                 i_cfg,
    output logic signed [TANHS_W-1:0] o_tanh
);

    logic [TANH_W-1:0] w_rom [TANH_ENTRIES];

    for (genvar k = 0; k < TANH_ENTRIES; k++) begin : g_rom
        localparam logic [63:0] P   = exp_neg_q32(k);
        localparam logic [63:0] DEN = ONE_Q32 + P;
        localparam logic [63:0] V   = ((ONE_Q32 - P) * 64'd65536 + DEN / 2) / DEN;
        assign w_rom[k] = TANH_W'(V);
    end

    logic [ROW_W-1:0]               w_mag;
    t_sgn                           w_sgn;
    logic [NUM_W-1:0]               w_num;
    logic [NUM_W+RECIP_W-1:0]       w_prod;
    logic [QC_W-1:0]                w_qc;
    logic [TANH_W-1:0]              w_mag_out;

    logic [NUM_W-1:0]               r_num;
    t_tanh_ctl                      r_ctl_a;
    logic [NUM_W-1:0]               r_q;
    t_tanh_ctl                      r_ctl_b;
    logic [TANH_W-1:0]              r_tab;
    logic                           r_sat;
    t_tanh_ctl                      r_ctl_c;
    logic signed [TANHS_W-1:0]      r_tanh;

    always_comb begin
        if (i_row == i_edge) begin
            w_sgn = SGN_ZERO;
            w_mag = '0;
        end else if (i_row > i_edge) begin
            w_sgn = SGN_POS;
            w_mag = i_row - i_edge;
        end else begin
            w_sgn = SGN_NEG;
            w_mag = i_edge - i_row;
        end
        w_num = NUM_W'({w_mag, 8'd0}) + NUM_W'(i_cfg.half);
    end

    assign w_prod = (NUM_W+RECIP_W)'(r_num) * (NUM_W+RECIP_W)'(i_cfg.recip);
    assign w_qc   = (32'(r_q) > Q_SAT) ? QC_W'(Q_SAT) : r_q[QC_W-1:0];

    always_comb begin
        w_mag_out = (r_ctl_c.hard || r_sat) ? TANH_ONE : r_tab;
    end

    always_ff @(posedge i_clk) begin
        r_num        <= w_num;
        r_ctl_a.sgn  <= w_sgn;
        r_ctl_a.hard <= i_cfg.hard;

        r_q     <= w_prod[RECIP_SHIFT +: NUM_W];
        r_ctl_b <= r_ctl_a;

        r_tab   <= w_rom[w_qc[TIDX_W-1:0]];
        r_sat   <= 32'(w_qc) >= TANH_ENTRIES;
        r_ctl_c <= r_ctl_b;

        case (r_ctl_c.sgn)
            SGN_POS: r_tanh <= TANHS_W'(w_mag_out);
            SGN_NEG: r_tanh <= -TANHS_W'(w_mag_out);
            default: r_tanh <= '0;
        endcase
    end

    assign o_tanh = r_tanh;

endmodule

FILE: hdl/tsb_blend_lane.sv
module tsb_blend_lane
    import tsb_pkg::*;
(
    input  logic               i_clk,
    input  logic [ALPHA_W-1:0] i_alpha,
    input  logic [PIX_W-1:0]   i_sharp,
    input  logic [PIX_W-1:0]   i_soft,
    output logic [PIX_W-1:0]   o_mixed
);

    logic [23:0] w_ps;
    logic [16:0] w_inv;
    logic [24:0] w_pb;
    logic [25:0] w_sum;
    logic [9:0]  w_acc;
    logic [PIX_W-1:0] r_mixed;

    assign w_ps  = 24'(i_alpha) * 24'(i_sharp);
    assign w_inv = 17'h10000 - 17'(i_alpha);
    assign w_pb  = 25'(w_inv) * 25'(i_soft);
    assign w_sum = 26'(w_ps) + 26'(w_pb) + 26'd32768;
    assign w_acc = w_sum[25:16];

    always_ff @(posedge i_clk) begin
        r_mixed <= (w_acc > 10'd255) ? 8'd255 : w_acc[PIX_W-1:0];
    end

    assign o_mixed = r_mixed;

endmodule

FILE: hdl/tilt_shift_row_blend.sv
// Channel   Direction  Handshake           Payload
// item      in         start, busy         i_row, i_sharp_*, i_soft_*
// result    out        o_valid strobe      o_mixed_red, o_mixed_green, o_mixed_blue
// config    in         i_cfg_we            i_cfg_index, i_cfg_data
//
// One item is accepted in every cycle while busy is low; its result is registered
// in the row register, the tanh lanes, the alpha register and the blend lanes,
// and o_valid marks it. The tanh lanes hold a reciprocal multiply and a table read.
// The reset is synchronous and clears the configuration and the valid pipeline.
// The busy output is high for one cycle after reset and low from then on.
// Results are shown for one cycle and cannot be held off by the receiver.
`include "assert_macros.svh"

module tilt_shift_row_blend
    import tsb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [ROW_W-1:0]     i_row,
    input  logic [PIX_W-1:0]     i_sharp_red,
    input  logic [PIX_W-1:0]     i_sharp_green,
    input  logic [PIX_W-1:0]     i_sharp_blue,
    input  logic [PIX_W-1:0]     i_soft_red,
    input  logic [PIX_W-1:0]     i_soft_green,
    input  logic [PIX_W-1:0]     i_soft_blue,
    output logic                 o_valid,
    output logic [PIX_W-1:0]     o_mixed_red,
    output logic [PIX_W-1:0]     o_mixed_green,
    output logic [PIX_W-1:0]     o_mixed_blue,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int LAT        = 7;
    localparam int PIX_STAGES = LAT - 1;

    logic [ROW_W-1:0]   r_focus_top;
    logic [ROW_W-1:0]   r_focus_bottom;
    logic [DECAY_W-1:0] r_decay;
    logic               r_busy;
    logic [LAT-1:0]     r_vld;
    logic [RECIP_W-1:0] r_recip;
    logic [ROW_W-1:0]   r_row;
    t_pix               r_pix [PIX_STAGES];
    logic [ALPHA_W-1:0] r_alpha;

    logic [RECIP_W-1:0]        w_recip [DECAY_CODES];
    t_edge_cfg                 w_cfg;
    logic signed [TANHS_W-1:0] w_tanh_top;
    logic signed [TANHS_W-1:0] w_tanh_bot;
    logic signed [TANHS_W:0]   w_diff;
    logic [TANH_W-1:0]         w_half_diff;
    logic [PIX_W-1:0]          w_mixed [3];

    for (genvar k = 0; k < DECAY_CODES; k++) begin : g_recip
        localparam int unsigned DC =
            (k > DECAY_MAX) ? DECAY_MAX : ((k == 0) ? 1 : k);
        localparam logic [63:0] RV =
            ((64'd1 << RECIP_SHIFT) + 64'(DC) - 64'd1) / 64'(DC);
        assign w_recip[k] = RECIP_W'(RV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_top    <= '0;
            r_focus_bottom <= '0;
            r_decay        <= '0;
            r_busy         <= 1'b1;
            r_vld          <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[LAT-2:0], start && !r_busy};
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FOCUS_TOP:    r_focus_top    <= i_cfg_data[ROW_W-1:0];
                    CFG_FOCUS_BOTTOM: r_focus_bottom <= i_cfg_data[ROW_W-1:0];
                    CFG_DECAY:        r_decay        <= i_cfg_data[DECAY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_recip  <= w_recip[r_decay];
        r_row    <= clamp_row(i_row);
        r_pix[0] <= '{sharp: {i_sharp_blue, i_sharp_green, i_sharp_red},
                      blur:  {i_soft_blue, i_soft_green, i_soft_red}};
        for (int s = 1; s < PIX_STAGES; s++) begin
            r_pix[s] <= r_pix[s-1];
        end
    end

    always_comb begin
        w_cfg.half  = clamp_decay(r_decay) >> 1;
        w_cfg.hard  = (r_decay == '0);
        w_cfg.recip = r_recip;
    end

    tsb_tanh_lane u_lane_top (
        .i_clk  (i_clk),
        .i_row  (r_row),
        .i_edge (clamp_row(r_focus_top)),
        .i_cfg  (w_cfg),
        .o_tanh (w_tanh_top)
    );

    tsb_tanh_lane u_lane_bot (
        .i_clk  (i_clk),
        .i_row  (r_row),
        .i_edge (clamp_row(r_focus_bottom)),
        .i_cfg  (w_cfg),
        .o_tanh (w_tanh_bot)
    );

    assign w_diff      = (TANHS_W+1)'(w_tanh_top) - (TANHS_W+1)'(w_tanh_bot);
    assign w_half_diff = w_diff[TANHS_W-1:1];

    always_ff @(posedge i_clk) begin
        if (w_diff[TANHS_W]) begin
            r_alpha <= '0;
        end else if (w_half_diff > TANH_W'(2 ** ALPHA_W - 1)) begin
            r_alpha <= '1;
        end else begin
            r_alpha <= w_half_diff[ALPHA_W-1:0];
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_blend
        tsb_blend_lane u_blend (
            .i_clk   (i_clk),
            .i_alpha (r_alpha),
            .i_sharp (r_pix[PIX_STAGES-1].sharp[c]),
            .i_soft  (r_pix[PIX_STAGES-1].blur[c]),
            .o_mixed (w_mixed[c])
        );
    end

    assign busy          = r_busy;
    assign o_valid       = r_vld[LAT-1];
    assign o_mixed_red   = w_mixed[0];
    assign o_mixed_green = w_mixed[1];
    assign o_mixed_blue  = w_mixed[2];

    `ASSERT_HOLDS(a_valid_follows_accept, o_valid |-> $past(start && !busy, LAT),
        "result strobe without a matching accepted item")
    `ASSERT_HOLDS(a_equal_tanh_zero_alpha, (w_tanh_top == w_tanh_bot) |=> (r_alpha == '0),
        "equal edge weights did not give a zero alpha")
    `ASSERT_NEVER(a_zero_alpha_gives_soft,
        $past(r_vld[LAT-2] && (r_alpha == '0)) &&
        (o_mixed_red != $past(r_pix[PIX_STAGES-1].blur[0])),
        "zero alpha did not pass the blurred red channel through")

endmodule

FILE: dv/tilt_shift_row_blend_tb.sv
module tilt_shift_row_blend_tb;
    import tsb_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = CFG_IDX_W'(3);
    localparam int ITEMS_PER_PHASE = 75;
    localparam int RANDOM_PHASES   = 10;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] sharp_red;
        logic [PIX_W-1:0] sharp_green;
        logic [PIX_W-1:0] sharp_blue;
        logic [PIX_W-1:0] soft_red;
        logic [PIX_W-1:0] soft_green;
        logic [PIX_W-1:0] soft_blue;
    } pixel_item_t;

    typedef struct {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } mix_rgb_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [ROW_W-1:0]     i_row = '0;
    logic [PIX_W-1:0]     i_sharp_red = '0;
    logic [PIX_W-1:0]     i_sharp_green = '0;
    logic [PIX_W-1:0]     i_sharp_blue = '0;
    logic [PIX_W-1:0]     i_soft_red = '0;
    logic [PIX_W-1:0]     i_soft_green = '0;
    logic [PIX_W-1:0]     i_soft_blue = '0;
    logic                 o_valid;
    logic [PIX_W-1:0]     o_mixed_red;
    logic [PIX_W-1:0]     o_mixed_green;
    logic [PIX_W-1:0]     o_mixed_blue;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic [TANH_W-1:0]  tanh_lut [TANH_ENTRIES];
    logic [ROW_W-1:0]   band_top = '0;
    logic [ROW_W-1:0]   band_bottom = '0;
    logic [DECAY_W-1:0] band_decay = '0;

    pixel_item_t pending_pix [$];
    pixel_item_t on_port;
    mix_rgb_t    expected_mix [$];
    int          sender_idle_pct = 0;
    int          mismatches = 0;

    tilt_shift_row_blend dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_row         (i_row),
        .i_sharp_red   (i_sharp_red),
        .i_sharp_green (i_sharp_green),
        .i_sharp_blue  (i_sharp_blue),
        .i_soft_red    (i_soft_red),
        .i_soft_green  (i_soft_green),
        .i_soft_blue   (i_soft_blue),
        .o_valid       (o_valid),
        .o_mixed_red   (o_mixed_red),
        .o_mixed_green (o_mixed_green),
        .o_mixed_blue  (o_mixed_blue),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint unsigned decay_series_q32(int unsigned j);
        longint unsigned term;
        longint          acc;
        int unsigned     n;
        term = ONE_Q32;
        acc  = longint'(term);
        for (n = 1; n <= 20; n++) begin
            term = term * j / (128 * n);
            if (n % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        return longint'(acc);
    endfunction

    function automatic void build_tanh_lut();
        longint unsigned e1;
        longint unsigned p;
        longint unsigned den;
        int unsigned     k;
        int unsigned     m;
        e1 = decay_series_q32(128);
        for (k = 0; k < TANH_ENTRIES; k++) begin
            p = decay_series_q32(k % 128);
            for (m = 0; m < k / 128; m++) begin
                p = (p * e1) >> 32;
            end
            if (p > ONE_Q32) begin
                p = ONE_Q32;
            end
            den = ONE_Q32 + p;
            tanh_lut[k] = TANH_W'(((ONE_Q32 - p) * 65536 + den / 2) / den);
        end
    endfunction

    function automatic logic signed [TANHS_W-1:0] tanh_edge(logic [ROW_W-1:0] r,
                                                           logic [ROW_W-1:0] edge_row,
                                                           logic [DECAY_W-1:0] d);
        logic [ROW_W-1:0]  row_gap;
        logic [31:0]       q;
        logic [TANH_W-1:0] t;
        if (r == edge_row) begin
            return '0;
        end
        row_gap = (r > edge_row) ? r - edge_row : edge_row - r;
        if (d == 0) begin
            t = TANH_ONE;
        end else begin
            q = (32'(row_gap) * 256 + 32'(d) / 2) / 32'(d);
            if (q > Q_SAT) begin
                q = Q_SAT;
            end
            t = (q < TANH_ENTRIES) ? tanh_lut[q] : TANH_ONE;
        end
        return (r > edge_row) ? $signed({1'b0, t}) : -$signed({1'b0, t});
    endfunction

    function automatic logic [PIX_W-1:0] mix_channel(logic [ALPHA_W-1:0] a,
                                                     logic [PIX_W-1:0] s,
                                                     logic [PIX_W-1:0] b);
        logic [31:0] acc;
        acc = (32'(a) * s + (32'd65536 - a) * b + 32'd32768) >> 16;
        return (acc > 255) ? PIX_W'(255) : PIX_W'(acc);
    endfunction

    function automatic mix_rgb_t predict_mix(pixel_item_t px);
        logic [DECAY_W-1:0] d;
        logic [ALPHA_W-1:0] alpha;
        int                 diff;
        mix_rgb_t           res;
        d = (band_decay > DECAY_MAX) ? DECAY_W'(DECAY_MAX) : band_decay;
        diff = int'(tanh_edge(px.row, band_top, d)) - int'(tanh_edge(px.row, band_bottom, d));
        if (diff < 0) begin
            alpha = '0;
        end else if ((diff >>> 1) > 65535) begin
            alpha = '1;
        end else begin
            alpha = ALPHA_W'(diff >>> 1);
        end
        res.red   = mix_channel(alpha, px.sharp_red, px.soft_red);
        res.green = mix_channel(alpha, px.sharp_green, px.soft_green);
        res.blue  = mix_channel(alpha, px.sharp_blue, px.soft_blue);
        return res;
    endfunction

    always @(posedge i_clk) begin : drive_proc
        pixel_item_t next_pix;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || !busy) begin
            if (start) begin
                expected_mix.push_back(predict_mix(on_port));
            end
            if (pending_pix.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_pix = pending_pix.pop_front();
                start         <= 1'b1;
                on_port       <= next_pix;
                i_row         <= next_pix.row;
                i_sharp_red   <= next_pix.sharp_red;
                i_sharp_green <= next_pix.sharp_green;
                i_sharp_blue  <= next_pix.sharp_blue;
                i_soft_red    <= next_pix.soft_red;
                i_soft_green  <= next_pix.soft_green;
                i_soft_blue   <= next_pix.soft_blue;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_channel(string chan, logic [PIX_W-1:0] want, logic [PIX_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, chan, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : check_proc
        mix_rgb_t want;
        if (i_rst_n && o_valid) begin
            if (expected_mix.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d %0d %0d",
                         $time, o_mixed_red, o_mixed_green, o_mixed_blue);
                mismatches++;
            end else begin
                want = expected_mix.pop_front();
                check_channel("mixed_red", want.red, o_mixed_red);
                check_channel("mixed_green", want.green, o_mixed_green);
                check_channel("mixed_blue", want.blue, o_mixed_blue);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FOCUS_TOP:    band_top = val;
            CFG_FOCUS_BOTTOM: band_bottom = val;
            CFG_DECAY:        band_decay = val[DECAY_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic set_band(int top, int bottom, int dec);
        write_reg(CFG_FOCUS_TOP, CFG_W'(top));
        write_reg(CFG_FOCUS_BOTTOM, CFG_W'(bottom));
        write_reg(CFG_DECAY, {CFG_W'($urandom_range(0, 31)) << DECAY_W} | CFG_W'(dec));
    endtask

    function automatic void push_pixel(int row, int sr, int sg, int sb, int tr, int tg, int tb);
        pixel_item_t px;
        px.row         = ROW_W'(row);
        px.sharp_red   = PIX_W'(sr);
        px.sharp_green = PIX_W'(sg);
        px.sharp_blue  = PIX_W'(sb);
        px.soft_red    = PIX_W'(tr);
        px.soft_green  = PIX_W'(tg);
        px.soft_blue   = PIX_W'(tb);
        pending_pix.push_back(px);
    endfunction

    function automatic int rand_channel();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int rand_row();
        int pick;
        int r;
        pick = $urandom_range(9);
        if (pick < 5) begin
            r = $urandom_range(0, 4 * band_decay + 8);
            if ($urandom_range(1) == 1) begin
                r = -r;
            end
            r += ($urandom_range(1) == 1) ? int'(band_top) : int'(band_bottom);
            if (r < 0) begin
                r = 0;
            end
            if (r > MAX_ROWS - 1) begin
                r = MAX_ROWS - 1;
            end
            return r;
        end else if (pick == 5) begin
            return 0;
        end else if (pick == 6) begin
            return MAX_ROWS - 1;
        end
        return $urandom_range(0, MAX_ROWS - 1);
    endfunction

    task automatic drain();
        do begin
            @(negedge i_clk);
        end while (pending_pix.size() != 0 || start || expected_mix.size() != 0);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin : stimulus_proc
        int idle_mix [4];
        int ph;
        int n;
        int top;
        int bot;
        int dec;
        idle_mix = '{0, 71, 16, 0};
        build_tanh_lut();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        push_pixel(0, 255, 255, 255, 0, 0, 0);
        push_pixel(1, 0, 128, 255, 255, 127, 0);
        push_pixel(4095, 0, 0, 0, 255, 255, 255);
        drain();

        set_band(100, 200, 0);
        @(negedge i_clk);
        push_pixel(50, 255, 0, 77, 0, 255, 200);
        push_pixel(100, 255, 0, 77, 0, 255, 200);
        push_pixel(150, 255, 255, 255, 0, 0, 0);
        push_pixel(200, 255, 0, 77, 0, 255, 200);
        push_pixel(250, 255, 0, 77, 0, 255, 200);
        drain();

        write_reg(CFG_DECAY, CFG_W'(1));
        @(negedge i_clk);
        push_pixel(99, 200, 100, 50, 10, 20, 30);
        push_pixel(100, 200, 100, 50, 10, 20, 30);
        push_pixel(101, 200, 100, 50, 10, 20, 30);
        push_pixel(150, 255, 255, 255, 0, 0, 0);
        push_pixel(199, 200, 100, 50, 10, 20, 30);
        push_pixel(201, 200, 100, 50, 10, 20, 30);
        drain();

        set_band(1000, 1100, 127);
        @(negedge i_clk);
        push_pixel(1000, 240, 15, 170, 5, 250, 85);
        push_pixel(1050, 240, 15, 170, 5, 250, 85);
        push_pixel(900, 240, 15, 170, 5, 250, 85);
        push_pixel(1300, 240, 15, 170, 5, 250, 85);
        drain();

        set_band(3000, 500, 100);
        @(negedge i_clk);
        push_pixel(500, 255, 255, 255, 0, 0, 0);
        push_pixel(1750, 255, 255, 255, 0, 0, 0);
        push_pixel(3000, 255, 255, 255, 0, 0, 0);
        drain();

        set_band(4095, 4095, 100);
        write_reg(CFG_IDX_SPARE, 12'hFFF);
        @(negedge i_clk);
        push_pixel(4095, 255, 255, 255, 0, 0, 0);
        push_pixel(0, 255, 255, 255, 0, 0, 0);
        push_pixel(4000, 255, 255, 255, 0, 0, 0);
        drain();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    top = 0;    bot = 4095; dec = 100;
                end
                1: begin
                    top = 4095; bot = 0;    dec = 1;
                end
                2: begin
                    top = 2000; bot = 2000; dec = 0;
                end
                3: begin
                    top = 0;    bot = 0;    dec = 127;
                end
                default: begin
                    top = $urandom_range(0, MAX_ROWS - 1);
                    if ($urandom_range(3) == 0) begin
                        bot = $urandom_range(0, MAX_ROWS - 1);
                    end else begin
                        bot = top + $urandom_range(0, 1500);
                        if (bot > MAX_ROWS - 1) begin
                            bot = MAX_ROWS - 1;
                        end
                    end
                    dec = ($urandom_range(3) == 0) ? $urandom_range(0, 127)
                                                   : $urandom_range(1, 40);
                end
            endcase
            set_band(top, bot, dec);
            if (ph % 3 == 1) begin
                write_reg(CFG_IDX_SPARE, CFG_W'($urandom_range(0, 4095)));
            end
            sender_idle_pct = idle_mix[ph % 4];
            @(negedge i_clk);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_pixel(rand_row(), rand_channel(), rand_channel(), rand_channel(),
                           rand_channel(), rand_channel(), rand_channel());
            end
            drain();
        end

        if (mismatches == 0 && expected_mix.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
